[rtl/slab_point_location_counter_defines.svh]
// Assertion macros shared by the block's RTL.
`ifndef SLAB_POINT_LOCATION_COUNTER_DEFINES_SVH
`define SLAB_POINT_LOCATION_COUNTER_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SPLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SPLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/splc_pkg.sv]
// ----------------------------------------------------------------------------
// splc_pkg
// Command codes and state encoding for the slab point-location counter.
// ----------------------------------------------------------------------------
package splc_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_LOCATE = 2'd2,
		CMD_QUERY  = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_LD_RD,
		ST_LD_CMP,
		ST_LC_RD,
		ST_LC_MUL,
		ST_LC_CMP,
		ST_LC_CRD,
		ST_LC_CWR,
		ST_QY_RD,
		ST_QY_ACC,
		ST_DONE
	} state_t;

	localparam int unsigned REG_TOP_Y    = 0;
	localparam int unsigned REG_BOTTOM_Y = 1;

endpackage

[rtl/splc_ptable.sv]
// ----------------------------------------------------------------------------
// splc_ptable
// Partition table memory: top and bottom x, one write and one read port.
// ----------------------------------------------------------------------------
module splc_ptable #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int CW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [CW-1:0] wtop,
	input  logic [CW-1:0] wbot,
	input  logic [AW-1:0] raddr,
	output logic [CW-1:0] rtop,
	output logic [CW-1:0] rbot
);
	logic [2*CW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wtop, wbot};
		end
		{rtop, rbot} <= mem[raddr];
	end
endmodule

[rtl/splc_bins.sv]
// ----------------------------------------------------------------------------
// splc_bins
// Bin counter memory: one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module splc_bins #(
	parameter int DEPTH = 1025,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/slab_point_location_counter.sv]
// ----------------------------------------------------------------------------
// slab_point_location_counter
// Bins points between sorted straight partitions and keeps a per-bin count.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   command  | start / busy          | cmd, top_x, bottom_x, point_x, point_y,
//            |                       | wanted_count
//   result   | done (one cycle)      | bin_index, bins_matching, status
//   config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// With n partitions loaded: clear sweeps the bin memory one entry per cycle.
// Load shifts the table one entry at a time from the end down to the insert
// point; a load into a full table goes straight to done. Locate runs one binary
// search probe after another (memory read, multiply, compare), then a
// read-modify-write of the bin counter. Query reads bins 0..n once each. The bin
// memory port bounds clear and query; the two multipliers bound locate. After
// reset the bin memory is swept to zero while busy is held high. The receiver
// cannot stall the result.
// ----------------------------------------------------------------------------
`include "slab_point_location_counter_defines.svh"

module slab_point_location_counter #(
	parameter int MAX_PARTITIONS = 1024,
	parameter int COORD_BITS     = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            cmd,
	input  logic signed [15:0]    top_x,
	input  logic signed [15:0]    bottom_x,
	input  logic signed [15:0]    point_x,
	input  logic signed [15:0]    point_y,
	input  logic [15:0]           wanted_count,
	output logic                  done,
	output logic [10:0]           bin_index,
	output logic [10:0]           bins_matching,
	output logic                  status,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data
);
	import splc_pkg::*;

	localparam int AW  = $clog2(MAX_PARTITIONS);
	localparam int BW  = $clog2(MAX_PARTITIONS + 1);
	localparam int CW  = COORD_BITS;
	localparam int DW  = CW + 1;
	localparam int PW  = 2 * DW;
	localparam int AWE = (AW < 1) ? 1 : AW;

	// Configuration registers, low COORD_BITS bits of the written data.
	logic signed [CW-1:0] top_y_q, bottom_y_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_y_q    <= '0;
			bottom_y_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == 1'(REG_TOP_Y)) begin
				top_y_q <= cfg_data[CW-1:0];
			end else begin
				bottom_y_q <= cfg_data[CW-1:0];
			end
		end
	end

	state_t state_q, state_d;
	logic [BW-1:0] total_q;
	logic [BW-1:0] ptr_q;        // clear/query sweep index, load slot
	logic [BW:0]   lo_q, hi_q;   // search bounds, 1-based
	logic [BW-1:0] found_q;
	logic [BW-1:0] mid_q;
	logic [1:0]    cmd_q;
	logic signed [CW-1:0] nt_q, nb_q, px_q, py_q;
	logic [15:0]   want_q;
	logic [10:0]   cnt_q;
	logic          full_q;
	logic          init_q;       // reset-time clear in progress

	// Partition table ports.
	logic          pt_we;
	logic [AWE-1:0] pt_waddr, pt_raddr;
	logic [CW-1:0] pt_wtop, pt_wbot, pt_rtop, pt_rbot;

	splc_ptable #(.DEPTH(MAX_PARTITIONS), .AW(AWE), .CW(CW)) u_ptable (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wtop(pt_wtop), .wbot(pt_wbot),
		.raddr(pt_raddr), .rtop(pt_rtop), .rbot(pt_rbot)
	);

	// Bin counter ports.
	logic          bn_we;
	logic [BW-1:0] bn_waddr, bn_raddr;
	logic [15:0]   bn_wdata, bn_rdata;

	splc_bins #(.DEPTH(MAX_PARTITIONS + 1), .AW(BW)) u_bins (
		.clk(clk), .we(bn_we), .waddr(bn_waddr), .wdata(bn_wdata),
		.raddr(bn_raddr), .rdata(bn_rdata)
	);

	// Cross product: two products registered, compared next cycle.
	logic signed [PW-1:0] p1_q, p2_q;
	logic signed [DW-1:0] d_bt, d_py, d_pt, d_by;
	assign d_bt = DW'(signed'(pt_rbot)) - DW'(signed'(pt_rtop));
	assign d_py = DW'(py_q) - DW'(top_y_q);
	assign d_pt = DW'(px_q) - DW'(signed'(pt_rtop));
	assign d_by = DW'(bottom_y_q) - DW'(top_y_q);

	logic [BW:0] mid_c;
	assign mid_c = (lo_q + hi_q) >> 1;

	logic right_c;
	assign right_c = (p1_q >= p2_q);

	logic [BW-1:0] ptr_m1;
	assign ptr_m1 = ptr_q - 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_t'(cmd))
						CMD_CLEAR:  state_d = ST_CLR;
						CMD_LOAD:   state_d = (total_q >= BW'(MAX_PARTITIONS)) ?
						                      ST_DONE : ST_LD_RD;
						CMD_LOCATE: state_d = ST_LC_RD;
						CMD_QUERY:  state_d = ST_QY_RD;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_CLR:    state_d = (ptr_q == BW'(MAX_PARTITIONS)) ?
			                     (init_q ? ST_IDLE : ST_DONE) : ST_CLR;
			ST_LD_RD:  state_d = (ptr_q == '0) ? ST_DONE : ST_LD_CMP;
			ST_LD_CMP: state_d = (signed'(pt_rtop) > nt_q) ? ST_LD_RD : ST_DONE;
			ST_LC_RD:  state_d = (lo_q <= hi_q) ? ST_LC_MUL : ST_LC_CRD;
			ST_LC_MUL: state_d = ST_LC_CMP;
			ST_LC_CMP: state_d = ST_LC_RD;
			ST_LC_CRD: state_d = ST_LC_CWR;
			ST_LC_CWR: state_d = ST_DONE;
			ST_QY_RD:  state_d = (ptr_q == total_q) ? ST_QY_ACC : ST_QY_RD;
			ST_QY_ACC: state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		pt_we    = 1'b0;
		pt_waddr = AWE'(ptr_q);
		pt_wtop  = nt_q;
		pt_wbot  = nb_q;
		pt_raddr = AWE'(ptr_m1);
		bn_we    = 1'b0;
		bn_waddr = ptr_q;
		bn_wdata = '0;
		bn_raddr = ptr_q;
		unique case (state_q)
			ST_CLR: bn_we = 1'b1;
			ST_LD_RD: begin
				// Place new entry at ptr; a later shift overwrites it if needed.
				pt_we = 1'b1;
			end
			ST_LD_CMP: begin
				if (signed'(pt_rtop) > nt_q) begin
					pt_we   = 1'b1;
					pt_wtop = pt_rtop;
					pt_wbot = pt_rbot;
				end
			end
			ST_LC_RD:  pt_raddr = AWE'(mid_c - 1'b1);
			ST_LC_CRD: bn_raddr = found_q;
			ST_LC_CWR: begin
				bn_we    = 1'b1;
				bn_waddr = found_q;
				bn_wdata = (bn_rdata == 16'hFFFF) ? bn_rdata : bn_rdata + 16'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		p1_q <= PW'(d_bt) * PW'(d_py);
		p2_q <= PW'(d_pt) * PW'(d_by);
		if (state_q == ST_IDLE && start) begin
			cmd_q  <= cmd;
			nt_q   <= top_x[CW-1:0];
			nb_q   <= bottom_x[CW-1:0];
			px_q   <= point_x[CW-1:0];
			py_q   <= point_y[CW-1:0];
			want_q <= wanted_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b1;
			total_q <= '0;
			ptr_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			found_q <= '0;
			mid_q   <= '0;
			cnt_q   <= '0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					init_q <= 1'b0;
					full_q <= 1'b0;
					cnt_q  <= '0;
					found_q <= '0;
					lo_q   <= (BW+1)'(1);
					hi_q   <= {1'b0, total_q};
					ptr_q  <= (start && cmd_t'(cmd) == CMD_LOAD) ? total_q : '0;
					if (start && cmd_t'(cmd) == CMD_LOAD &&
					    total_q >= BW'(MAX_PARTITIONS)) begin
						full_q <= 1'b1;
					end
					if (start && cmd_t'(cmd) == CMD_CLEAR) begin
						total_q <= '0;
					end
				end
				ST_CLR: ptr_q <= ptr_q + 1'b1;
				ST_LD_RD: if (ptr_q == '0) total_q <= total_q + 1'b1;
				ST_LD_CMP: begin
					if (signed'(pt_rtop) > nt_q) begin
						ptr_q <= ptr_m1;
					end else begin
						total_q <= total_q + 1'b1;
					end
				end
				ST_LC_RD: mid_q <= BW'(mid_c);
				ST_LC_CMP: begin
					if (right_c) begin
						found_q <= mid_q;
						lo_q    <= {1'b0, mid_q} + 1'b1;
					end else begin
						hi_q    <= {1'b0, mid_q} - 1'b1;
					end
				end
				ST_QY_RD: ptr_q <= ptr_q + 1'b1;
				ST_QY_ACC: ;
				default: ;
			endcase
			// Query accumulation: read data arrives in the cycle after its read address.
			if ((state_q == ST_QY_RD && ptr_q != '0) || state_q == ST_QY_ACC) begin
				if (bn_rdata == want_q) cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Outputs.
	always_comb begin
		busy          = (state_q != ST_IDLE);
		done          = (state_q == ST_DONE);
		bin_index     = '0;
		bins_matching = '0;
		status        = 1'b0;
		if (done) begin
			unique case (cmd_t'(cmd_q))
				CMD_LOCATE: bin_index     = 11'(found_q);
				CMD_QUERY:  bins_matching = cnt_q;
				CMD_LOAD:   status        = full_q;
				default: ;
			endcase
		end
	end

	// The result strobe is a pulse and is never held high.
	`SPLC_ASSERT_NEXT(a_done_one, clk, arst_n, done, !done, "done held")
	// A located bin never exceeds the table count.
	`SPLC_ASSERT_IMP(a_bin_range, clk, arst_n, done, bin_index <= 11'(total_q),
		"bin out of range")
	// The table never grows past its capacity.
	`SPLC_ASSERT_IMP(a_total_cap, clk, arst_n, 1'b1, total_q <= BW'(MAX_PARTITIONS),
		"table overflow")
endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the slab point-location counter. A behavioral
// predictor keeps its own copy of the partition table, the bin counters and
// the two y registers; every accepted command transaction yields one expected
// result, and every done pulse is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import splc_pkg::*;

	localparam int PARTITION_CAP = 1024;
	localparam int STALL_LIMIT   = 20000;

	typedef logic signed [15:0] coord_t;

	typedef struct packed {
		logic [10:0] bin_index;
		logic [10:0] bins_matching;
		logic        status;
	} bin_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  cmd;
	coord_t      top_x;
	coord_t      bottom_x;
	coord_t      point_x;
	coord_t      point_y;
	logic [15:0] wanted_count;
	logic        done;
	logic [10:0] bin_index;
	logic [10:0] bins_matching;
	logic        status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;

	slab_point_location_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.top_x         (top_x),
		.bottom_x      (bottom_x),
		.point_x       (point_x),
		.point_y       (point_y),
		.wanted_count  (wanted_count),
		.done          (done),
		.bin_index     (bin_index),
		.bins_matching (bins_matching),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predicted copy of the block's state.
	coord_t      slab_top_y;
	coord_t      slab_bottom_y;
	coord_t      slab_part_top [PARTITION_CAP];
	coord_t      slab_part_bot [PARTITION_CAP];
	int          slab_part_total;
	logic [15:0] slab_bin_count [PARTITION_CAP + 1];

	// Results still owed by the block, oldest first.
	bin_result_t pending_results[$];

	int  error_count;
	int  stall_cycles;
	bit  idle_allowed;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// A point is right of (or on) a partition when the cross product of the
	// partition direction and the point offset is not negative. All terms fit
	// easily in 64 bits, so the product is exact.
	function automatic bit point_right_of(int idx, coord_t px, coord_t py);
		longint tx;
		longint bx;
		longint ty;
		longint by;
		tx = slab_part_top[idx];
		bx = slab_part_bot[idx];
		ty = slab_top_y;
		by = slab_bottom_y;
		return ((bx - tx) * (longint'(py) - ty) - (longint'(px) - tx) * (by - ty)) >= 0;
	endfunction

	// Applies one command transaction to the predicted state and returns the
	// result the block must produce for it.
	function automatic bin_result_t predict_bin_result(cmd_t c, coord_t tx, coord_t bx,
			coord_t px, coord_t py, logic [15:0] wc);
		bin_result_t r;
		int pos;
		int lo;
		int hi;
		int mid;
		int found;
		int hits;
		r = '0;
		case (c)
			CMD_CLEAR: begin
				slab_part_total = 0;
				foreach (slab_bin_count[i]) slab_bin_count[i] = '0;
			end
			CMD_LOAD: begin
				if (slab_part_total >= PARTITION_CAP) begin
					r.status = 1'b1;
				end else begin
					// Equal top x keeps arrival order: the new one goes after.
					pos = slab_part_total;
					while (pos > 0 && slab_part_top[pos - 1] > tx) begin
						slab_part_top[pos] = slab_part_top[pos - 1];
						slab_part_bot[pos] = slab_part_bot[pos - 1];
						pos--;
					end
					slab_part_top[pos] = tx;
					slab_part_bot[pos] = bx;
					slab_part_total++;
				end
			end
			CMD_LOCATE: begin
				lo = 1;
				hi = slab_part_total;
				found = 0;
				while (lo <= hi) begin
					mid = (lo + hi) / 2;
					if (point_right_of(mid - 1, px, py)) begin
						found = mid;
						lo = mid + 1;
					end else begin
						hi = mid - 1;
					end
				end
				if (slab_bin_count[found] != 16'hFFFF)
					slab_bin_count[found]++;
				r.bin_index = 11'(found);
			end
			default: begin
				hits = 0;
				for (int i = 0; i <= slab_part_total; i++)
					if (slab_bin_count[i] == wc)
						hits++;
				r.bins_matching = 11'(hits);
			end
		endcase
		return r;
	endfunction

	// Handshakes are judged at the falling edge: busy, done and cfg_ready only
	// move at rising edges, so their value here is the one the next rising
	// edge sees.
	always @(negedge clk) begin
		bin_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: bin_index %0d bins_matching %0d status %0d",
					bin_index, bins_matching, status);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (bin_index !== want.bin_index) begin
					$error("bin_index expected %0d actual %0d", want.bin_index, bin_index);
					error_count++;
				end
				if (bins_matching !== want.bins_matching) begin
					$error("bins_matching expected %0d actual %0d",
						want.bins_matching, bins_matching);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, status);
					error_count++;
				end
			end
		end
	end

	// Watchdog: any transaction on any channel restarts the count. The reset
	// sweep and the longest load shift stay far below the limit.
	always @(negedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Sends one command transaction. Called and returning just after a rising
	// edge; start stays high so a following item can go out back to back.
	task automatic send_cmd(cmd_t c, coord_t tx, coord_t bx, coord_t px, coord_t py,
			logic [15:0] wc);
		start        <= 1'b1;
		cmd          <= c;
		top_x        <= tx;
		bottom_x     <= bx;
		point_x      <= px;
		point_y      <= py;
		wanted_count <= wc;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_results.push_back(predict_bin_result(c, tx, bx, px, py, wc));
	endtask

	// Random sender gap, now and then, while gaps are allowed.
	task automatic maybe_idle();
		if (idle_allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Holds off until every expected result has come and the block is idle.
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(int unsigned idx, coord_t value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= 1'(idx);
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_TOP_Y)
			slab_top_y = value;
		else
			slab_bottom_y = value;
	endtask

	task automatic set_slab(coord_t ty, coord_t by);
		write_reg(REG_TOP_Y, ty);
		write_reg(REG_BOTTOM_Y, by);
	endtask

	task automatic locate(coord_t px, coord_t py);
		send_cmd(CMD_LOCATE, '0, '0, px, py, '0);
	endtask

	task automatic query(logic [15:0] wc);
		send_cmd(CMD_QUERY, '0, '0, '0, '0, wc);
	endtask

	task automatic load(coord_t tx, coord_t bx);
		send_cmd(CMD_LOAD, tx, bx, '0, '0, '0);
	endtask

	// Empty table after reset: every point lands in bin 0, and a query of
	// zero sees the one bin as empty until a point arrives.
	task automatic test_empty_table();
		query(16'd0);
		locate(16'sh7FFF, -16'sh8000);
		query(16'd1);
		query(16'd0);
	endtask

	// Loads out of order, with equal top x, the coordinate extremes and points
	// exactly on a partition, which belong to the bin on its right.
	task automatic test_directed_locate();
		set_slab(-16'sh8000, 16'sh7FFF);
		send_cmd(CMD_CLEAR, '0, '0, '0, '0, '0);
		load(16'sd100, -16'sd100);
		load(-16'sh8000, 16'sh7FFF);
		load(16'sd100, 16'sd300);
		load(16'sh7FFF, -16'sh8000);
		load(16'sd0, 16'sd0);
		locate(-16'sh8000, -16'sh8000);
		locate(16'sh7FFF, 16'sh7FFF);
		locate(16'sd100, -16'sh8000);
		locate(16'sd0, 16'sd0);
		locate(16'sd300, 16'sh7FFF);
		locate(-16'sh8000, 16'sh7FFF);
		query(16'd1);
		query(16'd0);
		query(16'hFFFF);
		// Loading after locates leaves the counters where they are.
		load(-16'sd5, 16'sd5);
		query(16'd1);
		set_slab(16'sd50, 16'sd50);
		locate(16'sd1, 16'sd50);
		locate(16'sd1, 16'sd49);
		query(16'd0);
	endtask

	// Mostly loads and locates on a small table, with points often placed on
	// or next to an existing partition. Each phase uses its own y registers.
	task automatic test_random(int items);
		int    pick;
		int    idx;
		coord_t px;
		coord_t py;
		for (int n = 0; n < items; n++) begin
			case (n)
				0:   set_slab(coord_t'($urandom), coord_t'($urandom));
				90:  set_slab(16'sh7FFF, -16'sh8000);
				180: set_slab(16'sd7, 16'sd7);
				270: begin
					// The sender waits for the block to empty before this phase.
					drain();
					set_slab(coord_t'($urandom_range(0, 400) - 200),
						coord_t'($urandom_range(0, 400) - 200));
				end
				350: idle_allowed = 1'b0;
				default: ;
			endcase
			if (n % 60 == 59)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 4 || (slab_part_total > 48 && pick < 10)) begin
				send_cmd(CMD_CLEAR, coord_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), 16'($urandom));
			end else if (pick < 40) begin
				load(coord_t'($urandom), coord_t'($urandom));
			end else if (pick < 85) begin
				px = coord_t'($urandom);
				py = coord_t'($urandom);
				if (slab_part_total > 0 && $urandom_range(0, 1)) begin
					idx = $urandom_range(0, slab_part_total - 1);
					case ($urandom_range(0, 2))
						0: begin
							px = slab_part_top[idx] + coord_t'($urandom_range(0, 2) - 1);
							py = slab_top_y;
						end
						1: begin
							px = slab_part_bot[idx] + coord_t'($urandom_range(0, 2) - 1);
							py = slab_bottom_y;
						end
						default: begin
							px = coord_t'((int'(slab_part_top[idx]) + slab_part_bot[idx]) / 2);
							py = coord_t'((int'(slab_top_y) + slab_bottom_y) / 2);
						end
					endcase
				end
				send_cmd(CMD_LOCATE, coord_t'($urandom), coord_t'($urandom), px, py,
					16'($urandom));
			end else begin
				query($urandom_range(0, 1) ? 16'($urandom_range(0, 4)) : 16'($urandom));
			end
			maybe_idle();
		end
	endtask

	initial begin
		error_count  = 0;
		stall_cycles = 0;
		idle_allowed = 1'b1;
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_CLEAR;
		top_x        = '0;
		bottom_x     = '0;
		point_x      = '0;
		point_y      = '0;
		wanted_count = '0;
		cfg_valid    = 1'b0;
		cfg_index    = 1'b0;
		cfg_data     = '0;
		slab_top_y      = '0;
		slab_bottom_y   = '0;
		slab_part_total = 0;
		foreach (slab_bin_count[i]) slab_bin_count[i] = '0;
		foreach (slab_part_top[i]) begin
			slab_part_top[i] = '0;
			slab_part_bot[i] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_locate();
		test_random(426);

		// Let the last results arrive, then wait on for stray pulses.
		drain();
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
